FILE: src/lru_byte_budget_evictor_core_macros.svh
// Assertion macros for the byte-budget evictor.
`ifndef LRU_BYTE_BUDGET_EVICTOR_CORE_MACROS_SVH
`define LRU_BYTE_BUDGET_EVICTOR_CORE_MACROS_SVH
`ifndef SYNTH
`define LBE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lbe check failed");
`define LBE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lbe check failed");
`else
`define LBE_ASSERT_SAME(label, ante, cons)
`define LBE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/lbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_pkg
// Shared types and constants of the byte-budget LRU evictor.
// ----------------------------------------------------------------------------
package lbe_pkg;
   localparam int ENTRIES   = 32;
   localparam int RANK_W    = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int SIZE_BITS = 36;
   localparam int KEY_W     = 64;
   localparam int BYTE_W    = 41;
   localparam int EVC_W     = 32;
   localparam logic [BYTE_W-1:0] DEFAULT_BUDGET = 41'd4294967296;

   localparam logic [2:0] ACT_REGISTER   = 3'd0;
   localparam logic [2:0] ACT_UNREGISTER = 3'd1;
   localparam logic [2:0] ACT_TOUCH      = 3'd2;
   localparam logic [2:0] ACT_EVICT      = 3'd3;
   localparam logic [2:0] ACT_QUERY      = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE, OP_INSERT, OP_RESIZE, OP_DROP, OP_TOUCH
   } op_type;

   typedef enum logic [1:0] {
      PICK_MATCH, PICK_FREE, PICK_OLDEST
   } pick_type;

   typedef enum logic [1:0] {
      S_IDLE, S_EXEC, S_EVICT, S_OUT
   } state_type;

   typedef struct packed {
      op_type                op;
      pick_type              pick;
      logic [KEY_W-1:0]      key;
      logic [SIZE_BITS-1:0]  size;
      logic [RANK_W-1:0]     ref_rank;
      logic [RANK_W-1:0]     new_rank;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic sel;
   } stat_type;
endpackage

FILE: src/lbe_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_cell
// One table entry: key, size and age rank, with its own compare and update.
// ----------------------------------------------------------------------------
module lbe_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  lbe_pkg::cmd_type               cmd,
   input  logic                           free_in,
   output logic                           free_out,
   output lbe_pkg::stat_type              stat,
   output logic [lbe_pkg::KEY_W-1:0]      sel_key,
   output logic [lbe_pkg::SIZE_BITS-1:0]  sel_size,
   output logic [lbe_pkg::RANK_W-1:0]     sel_rank
);
   import lbe_pkg::*;

   logic                 valid_ff, valid_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [RANK_W-1:0]    rank_ff, rank_in;
   logic                 match, oldest, first_free, sel;

   assign match      = valid_ff && (key_ff == cmd.key);
   assign oldest     = valid_ff && (rank_ff == '0);
   // The first free cell along the chain takes a new tile.
   assign first_free = !valid_ff && !free_in;
   assign free_out   = free_in || !valid_ff;

   always_comb begin
      case (cmd.pick)
         PICK_MATCH: sel = match;
         PICK_FREE:  sel = first_free;
         default:    sel = oldest;
      endcase
   end

   assign stat.match = match;
   assign stat.sel   = sel;
   assign sel_key    = sel ? key_ff : '0;
   assign sel_size   = sel ? size_ff : '0;
   assign sel_rank   = sel ? rank_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      size_in  = size_ff;
      rank_in  = rank_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (sel) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               size_in  = cmd.size;
               rank_in  = cmd.new_rank;
            end
         end
         OP_RESIZE: begin
            if (sel) size_in = cmd.size;
         end
         OP_DROP: begin
            if (sel) valid_in = 1'b0;
            else if (valid_ff && rank_ff > cmd.ref_rank) rank_in = rank_ff - 1'b1;
         end
         OP_TOUCH: begin
            if (sel) rank_in = cmd.new_rank;
            else if (valid_ff && rank_ff > cmd.ref_rank) rank_in = rank_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff  <= key_in;
      size_ff <= size_in;
      rank_ff <= rank_in;
   end
endmodule

FILE: src/lru_byte_budget_evictor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_byte_budget_evictor_core
// LRU table of tiles kept against a byte budget, with eviction to a target.
// ----------------------------------------------------------------------------
// A request is accepted only while the block is idle. In the cycle after it
// is accepted, all 32 cells compare its key at once and, as its action
// demands, update their entries. For all but an evict request, the result is
// presented from the cycle after that. The next request is accepted in the
// cycle after the result is taken, so a stalled result holds the block
// longer. An evict request first passes through the compare step. It then
// passes one evict step per evicted tile and one for the final summary, and
// each of these is followed by a step that presents its result. The single
// result register sets the rate: the block holds each request until its last
// result is taken.
module lru_byte_budget_evictor_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_action,
   input  logic [63:0]                     req_tile_key,
   input  logic [35:0]                     req_tile_bytes,
   input  logic [40:0]                     req_target_bytes,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_is_resident,
   output logic [63:0]                     rsp_evicted_key,
   output logic [35:0]                     rsp_evicted_bytes,
   output logic [40:0]                     rsp_bytes_freed,
   output logic [40:0]                     rsp_bytes_used,
   output logic [40:0]                     rsp_bytes_available,
   output logic [5:0]                      rsp_tiles_resident,
   output logic [31:0]                     rsp_evicted_total,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [40:0]                     csr_wr_data
);
   import lbe_pkg::*;
`include "lru_byte_budget_evictor_core_macros.svh"

   state_type             state_ff, state_in;
   logic [2:0]            action_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [SIZE_BITS-1:0]  bytes_ff;
   logic [BYTE_W-1:0]     limit_ff, budget_ff, used_ff, used_in, freed_ff, freed_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [EVC_W-1:0]      evc_ff, evc_in;
   logic                  more_ff, more_in, emit;
   logic [1:0]            o_status;
   logic                  o_resident, o_last;
   logic [KEY_W-1:0]      o_key;
   logic [SIZE_BITS-1:0]  o_size;
   logic [BYTE_W-1:0]     o_freed;

   logic [1:0]  status_ff;
   logic        resident_ff, last_ff;
   logic [63:0] ekey_ff;
   logic [35:0] ebytes_ff;
   logic [40:0] rfreed_ff, rused_ff, ravail_ff;
   logic [5:0]  rcount_ff;
   logic [31:0] rtotal_ff;

   cmd_type               cmd;
   stat_type              stat [ENTRIES];
   logic [ENTRIES:0]      free_chain;
   logic [KEY_W-1:0]      c_key  [ENTRIES];
   logic [SIZE_BITS-1:0]  c_size [ENTRIES];
   logic [RANK_W-1:0]     c_rank [ENTRIES];
   logic [ENTRIES-1:0]    match_vec, sel_vec;
   logic                  any_match, any_sel;
   logic [KEY_W-1:0]      s_key;
   logic [SIZE_BITS-1:0]  s_size;
   logic [RANK_W-1:0]     s_rank;

   assign free_chain[0] = 1'b0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lbe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .free_in  (free_chain[g]),
         .free_out (free_chain[g+1]),
         .stat     (stat[g]),
         .sel_key  (c_key[g]),
         .sel_size (c_size[g]),
         .sel_rank (c_rank[g])
      );
   end

   always_comb begin
      s_key  = '0;
      s_size = '0;
      s_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = stat[i].match;
         sel_vec[i]   = stat[i].sel;
         s_key  = s_key | c_key[i];
         s_size = s_size | c_size[i];
         s_rank = s_rank | c_rank[i];
      end
   end
   assign any_match = |match_vec;
   assign any_sel   = |sel_vec;

   always_comb begin
      case (state_ff)
         S_IDLE:  state_in = req_valid ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = (action_ff == ACT_EVICT) ? S_EVICT : S_OUT;
         S_EVICT: state_in = S_OUT;
         S_OUT:   state_in = rsp_ready ? (more_ff ? S_EVICT : S_IDLE) : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = OP_NONE;
      cmd.pick     = PICK_MATCH;
      cmd.key      = key_ff;
      cmd.size     = bytes_ff;
      cmd.ref_rank = s_rank;
      cmd.new_rank = count_ff[RANK_W-1:0];
      used_in      = used_ff;
      count_in     = count_ff;
      evc_in       = evc_ff;
      freed_in     = freed_ff;
      more_in      = more_ff;
      emit         = 1'b0;
      o_status     = ST_OK;
      o_resident   = 1'b0;
      o_last       = 1'b1;
      o_key        = '0;
      o_size       = '0;
      o_freed      = '0;
      case (state_ff)
         S_IDLE: begin
            freed_in = '0;
            more_in  = 1'b0;
         end
         S_EXEC: begin
            emit = (action_ff != ACT_EVICT);
            case (action_ff)
               ACT_REGISTER: begin
                  if (any_match) begin
                     cmd.op  = OP_RESIZE;
                     used_in = used_ff - BYTE_W'(s_size) + BYTE_W'(bytes_ff);
                  end else if (free_chain[ENTRIES]) begin
                     cmd.pick = PICK_FREE;
                     cmd.op   = OP_INSERT;
                     used_in  = used_ff + BYTE_W'(bytes_ff);
                     count_in = count_ff + 1'b1;
                  end else begin
                     cmd.pick = PICK_FREE;
                     o_status = ST_FULL;
                  end
               end
               ACT_UNREGISTER: begin
                  if (any_match) begin
                     cmd.op   = OP_DROP;
                     used_in  = used_ff - BYTE_W'(s_size);
                     count_in = count_ff - 1'b1;
                  end else begin
                     o_status = ST_NOT_FOUND;
                  end
               end
               ACT_TOUCH: begin
                  cmd.new_rank = RANK_W'(count_ff - 1'b1);
                  if (any_match) cmd.op = OP_TOUCH;
                  else o_status = ST_NOT_FOUND;
               end
               ACT_QUERY: o_resident = any_match;
               default: ;
            endcase
         end
         S_EVICT: begin
            emit     = 1'b1;
            cmd.pick = PICK_OLDEST;
            if (used_ff > limit_ff && count_ff != '0 && any_sel) begin
               cmd.op   = OP_DROP;
               used_in  = used_ff - BYTE_W'(s_size);
               count_in = count_ff - 1'b1;
               freed_in = freed_ff + BYTE_W'(s_size);
               if (evc_ff != '1) evc_in = evc_ff + 1'b1;
               more_in  = 1'b1;
               o_last   = 1'b0;
               o_key    = s_key;
               o_size   = s_size;
            end else begin
               more_in  = 1'b0;
               o_freed  = freed_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         budget_ff <= DEFAULT_BUDGET;
         used_ff   <= '0;
         count_ff  <= '0;
         evc_ff    <= '0;
         more_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) budget_ff <= csr_wr_data;
         used_ff  <= used_in;
         count_ff <= count_in;
         evc_ff   <= evc_in;
         more_ff  <= more_in;
      end
      freed_ff <= freed_in;
      if (req_valid && req_ready) begin
         action_ff <= req_action;
         key_ff    <= req_tile_key;
         bytes_ff  <= req_tile_bytes[SIZE_BITS-1:0];
         limit_ff  <= (req_target_bytes != '0) ? req_target_bytes : budget_ff;
      end
      if (emit) begin
         status_ff   <= o_status;
         resident_ff <= o_resident;
         last_ff     <= o_last;
         ekey_ff     <= o_key;
         ebytes_ff   <= o_size;
         rfreed_ff   <= o_freed;
         rused_ff    <= used_in;
         ravail_ff   <= (budget_ff > used_in) ? budget_ff - used_in : '0;
         rcount_ff   <= count_in;
         rtotal_ff   <= evc_in;
      end
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = (state_ff == S_OUT);
   assign rsp_status          = status_ff;
   assign rsp_is_resident     = resident_ff;
   assign rsp_evicted_key     = ekey_ff;
   assign rsp_evicted_bytes   = ebytes_ff;
   assign rsp_bytes_freed     = rfreed_ff;
   assign rsp_bytes_used      = rused_ff;
   assign rsp_bytes_available = ravail_ff;
   assign rsp_tiles_resident  = rcount_ff;
   assign rsp_evicted_total   = rtotal_ff;
   assign rsp_last            = last_ff;

   `LBE_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(ENTRIES))
   `LBE_ASSERT_SAME(a_single_match, state_ff == S_EXEC, $onehot0(match_vec))
   `LBE_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_ff == S_EXEC)
   `LBE_ASSERT_SAME(a_no_overlap, rsp_valid, !req_ready)
endmodule
